// ----- hdl/duart_pkg.sv -----
`timescale 1ns / 1ps

package duart_pkg;

    // one input word: a bus access or a line event
    typedef struct packed {
        logic [2:0] action;
        logic [3:0] reg_addr;
        logic [7:0] write_data;
        logic       event_channel;
        logic [7:0] line_byte;
    } in_t;

    // one result word
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_modem_rx;
        logic       irq_modem_tx;
        logic       irq_diag_rx;
        logic       irq_diag_tx;
        logic       irq_timer;
        logic [7:0] out_port;
        logic       tx_start;
        logic       tx_channel;
        logic [8:0] tx_word;
        logic       rx_taken;
    } out_t;

    // action codes
    localparam logic [2:0] ACT_READ    = 3'd0;
    localparam logic [2:0] ACT_WRITE   = 3'd1;
    localparam logic [2:0] ACT_TICK    = 3'd2;
    localparam logic [2:0] ACT_ARRIVE  = 3'd3;
    localparam logic [2:0] ACT_DONE    = 3'd4;
    localparam logic [2:0] ACT_RELEASE = 3'd5;

    // register offsets
    localparam logic [3:0] ADR_MR_A  = 4'd0;
    localparam logic [3:0] ADR_SR_A  = 4'd1;
    localparam logic [3:0] ADR_CR_A  = 4'd2;
    localparam logic [3:0] ADR_HR_A  = 4'd3;
    localparam logic [3:0] ADR_ISR   = 4'd5;
    localparam logic [3:0] ADR_CTU   = 4'd6;
    localparam logic [3:0] ADR_CTL   = 4'd7;
    localparam logic [3:0] ADR_MR_B  = 4'd8;
    localparam logic [3:0] ADR_SR_B  = 4'd9;
    localparam logic [3:0] ADR_CR_B  = 4'd10;
    localparam logic [3:0] ADR_HR_B  = 4'd11;
    localparam logic [3:0] ADR_OPCR  = 4'd13;
    localparam logic [3:0] ADR_SETOP = 4'd14;
    localparam logic [3:0] ADR_CLROP = 4'd15;

    // command field values
    localparam logic [2:0] CMD_RST_MRA  = 3'd1;
    localparam logic [2:0] CMD_RST_TX   = 3'd3;
    localparam logic [2:0] CMD_RST_MRB  = 3'd4;

    // interrupt level positions
    localparam logic [2:0] IRQ_MRX = 3'd0;
    localparam logic [2:0] IRQ_MTX = 3'd1;
    localparam logic [2:0] IRQ_DRX = 3'd2;
    localparam logic [2:0] IRQ_DTX = 3'd3;
    localparam logic [2:0] IRQ_TMR = 3'd4;

    // output port bits with a special meaning
    localparam int unsigned OP_LOOP_B  = 2;
    localparam int unsigned OP_TIMER   = 3;
    localparam int unsigned OP_MRX     = 4;
    localparam int unsigned OP_DRX     = 5;
    localparam int unsigned OP_DTX     = 7;

endpackage

// ----- hdl/duart_regs.sv -----
`timescale 1ns / 1ps

module duart_regs (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  duart_pkg::in_t   item,
    output duart_pkg::out_t  result
);

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ARMED = 2'd1,
        PH_COUNT = 2'd2
    } phase_t;

    logic [7:0]  mode_reg     [4];
    logic [7:0]  mode_next    [4];
    logic [1:0]  mptr_reg,     mptr_next;
    logic [1:0]  rx_rdy_reg,   rx_rdy_next;
    logic [1:0]  tx_rdy_reg,   tx_rdy_next;
    logic [1:0]  tx_emp_reg,   tx_emp_next;
    logic [7:0]  hold_reg     [2];
    logic [7:0]  hold_next    [2];
    logic [1:0]  hwait_reg,    hwait_next;
    logic [1:0]  rx_en_reg,    rx_en_next;
    logic [1:0]  tx_en_reg,    tx_en_next;
    logic [7:0]  port_reg,     port_next;
    logic [15:0] cnt_reg,      cnt_next;
    logic [15:0] pre_reg,      pre_next;
    phase_t      phase_reg,    phase_next;
    logic        tmode_reg,    tmode_next;
    logic        isr_reg,      isr_next;
    logic [4:0]  irq_reg,      irq_next;

    always_comb
    begin
        logic       bch;
        logic       ech;
        logic [7:0] d;
        logic [2:0] cmd;
        logic [2:0] rx_idx;
        logic [2:0] tx_idx;
        logic [2:0] erx_idx;
        logic [2:0] etx_idx;
        logic [15:0] dec;

        bch     = item.reg_addr[3];
        ech     = item.event_channel;
        d       = item.write_data;
        cmd     = d[6:4];
        rx_idx  = bch ? duart_pkg::IRQ_DRX : duart_pkg::IRQ_MRX;
        tx_idx  = bch ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX;
        erx_idx = ech ? duart_pkg::IRQ_DRX : duart_pkg::IRQ_MRX;
        etx_idx = ech ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX;
        dec     = cnt_reg - 16'd1;

        mode_next   = mode_reg;
        mptr_next   = mptr_reg;
        rx_rdy_next = rx_rdy_reg;
        tx_rdy_next = tx_rdy_reg;
        tx_emp_next = tx_emp_reg;
        hold_next   = hold_reg;
        hwait_next  = hwait_reg;
        rx_en_next  = rx_en_reg;
        tx_en_next  = tx_en_reg;
        port_next   = port_reg;
        cnt_next    = cnt_reg;
        pre_next    = pre_reg;
        phase_next  = phase_reg;
        tmode_next  = tmode_reg;
        isr_next    = isr_reg;
        irq_next    = irq_reg;

        result = '0;

        unique case (item.action)
            duart_pkg::ACT_READ:
            begin
                unique case (item.reg_addr)
                    duart_pkg::ADR_SR_A, duart_pkg::ADR_SR_B:
                    begin
                        result.read_data = {4'b0, tx_emp_reg[bch], tx_rdy_reg[bch],
                                            1'b0, rx_rdy_reg[bch]};
                    end
                    duart_pkg::ADR_HR_A, duart_pkg::ADR_HR_B:
                    begin
                        rx_rdy_next[bch]   = 1'b0;
                        irq_next[rx_idx]   = 1'b0;
                        result.read_data   = hold_reg[bch];
                    end
                    duart_pkg::ADR_ISR:
                    begin
                        result.read_data = {4'b0, isr_reg, 3'b0};
                    end
                    duart_pkg::ADR_CTU:
                    begin
                        result.read_data = cnt_reg[15:8];
                    end
                    duart_pkg::ADR_CTL:
                    begin
                        result.read_data = cnt_reg[7:0];
                    end
                    duart_pkg::ADR_SETOP:
                    begin
                        // start counter: load and arm
                        cnt_next   = pre_reg;
                        phase_next = PH_ARMED;
                    end
                    duart_pkg::ADR_CLROP:
                    begin
                        // stop counter and clear its interrupt
                        phase_next                    = PH_STOP;
                        isr_next                      = 1'b0;
                        irq_next[duart_pkg::IRQ_TMR]  = 1'b0;
                        if (tmode_reg)
                        begin
                            port_next[duart_pkg::OP_TIMER] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            duart_pkg::ACT_WRITE:
            begin
                unique case (item.reg_addr)
                    duart_pkg::ADR_MR_A, duart_pkg::ADR_MR_B:
                    begin
                        mode_next[{bch, mptr_reg[bch]}] = d;
                        mptr_next[bch] = ~mptr_reg[bch];
                    end
                    duart_pkg::ADR_CR_A, duart_pkg::ADR_CR_B:
                    begin
                        if (cmd == duart_pkg::CMD_RST_MRA || cmd == duart_pkg::CMD_RST_MRB)
                        begin
                            mptr_next[bch] = 1'b0;
                        end
                        else if (cmd == duart_pkg::CMD_RST_TX)
                        begin
                            tx_en_next[bch]  = 1'b0;
                            tx_rdy_next[bch] = 1'b0;
                            irq_next[tx_idx] = 1'b0;
                        end
                        if (d[0])
                        begin
                            rx_en_next[bch] = 1'b1;
                        end
                        if (d[1])
                        begin
                            rx_en_next[bch] = 1'b0;
                        end
                        if (d[2] && !tx_en_next[bch])
                        begin
                            tx_en_next[bch]  = 1'b1;
                            tx_rdy_next[bch] = 1'b1;
                            tx_emp_next[bch] = 1'b1;
                            irq_next[tx_idx] = 1'b1;
                        end
                        if (d[3])
                        begin
                            tx_en_next[bch]  = 1'b0;
                            tx_rdy_next[bch] = 1'b0;
                            tx_emp_next[bch] = 1'b1;
                            irq_next[tx_idx] = 1'b0;
                        end
                    end
                    duart_pkg::ADR_HR_A, duart_pkg::ADR_HR_B:
                    begin
                        if ((bch && port_reg[duart_pkg::OP_LOOP_B]) ||
                            mode_reg[{bch, 1'b1}][7])
                        begin
                            // local loopback into the holding register
                            hold_next[bch]   = d;
                            rx_rdy_next[bch] = 1'b1;
                        end
                        else
                        begin
                            tx_rdy_next[bch]  = 1'b0;
                            tx_emp_next[bch]  = 1'b0;
                            irq_next[tx_idx]  = 1'b0;
                            result.tx_start   = 1'b1;
                            result.tx_channel = bch;
                            result.tx_word    = {bch & mode_reg[2][2], d};
                        end
                    end
                    duart_pkg::ADR_CTU:
                    begin
                        pre_next[15:8] = d;
                    end
                    duart_pkg::ADR_CTL:
                    begin
                        pre_next[7:0] = d;
                    end
                    duart_pkg::ADR_OPCR:
                    begin
                        tmode_next = (d[3:2] == 2'b01);
                    end
                    duart_pkg::ADR_SETOP:
                    begin
                        port_next = port_reg | d;
                        if (port_next[duart_pkg::OP_MRX])
                        begin
                            irq_next[duart_pkg::IRQ_MRX] = 1'b1;
                        end
                        if (port_next[duart_pkg::OP_DRX])
                        begin
                            irq_next[duart_pkg::IRQ_DRX] = 1'b1;
                        end
                        if (port_next[duart_pkg::OP_DTX])
                        begin
                            irq_next[duart_pkg::IRQ_DTX] = 1'b1;
                        end
                    end
                    duart_pkg::ADR_CLROP:
                    begin
                        port_next = port_reg & ~d;
                        if (!port_next[duart_pkg::OP_MRX])
                        begin
                            irq_next[duart_pkg::IRQ_MRX] = 1'b0;
                        end
                        if (!port_next[duart_pkg::OP_DRX])
                        begin
                            irq_next[duart_pkg::IRQ_DRX] = 1'b0;
                        end
                        if (!port_next[duart_pkg::OP_DTX])
                        begin
                            irq_next[duart_pkg::IRQ_DTX] = 1'b0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            duart_pkg::ACT_TICK:
            begin
                unique case (phase_reg)
                    PH_ARMED:
                    begin
                        phase_next = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        cnt_next = dec;
                        if (dec == 16'd0)
                        begin
                            isr_next = 1'b1;
                            if (tmode_reg)
                            begin
                                irq_next[duart_pkg::IRQ_TMR]   = 1'b1;
                                port_next[duart_pkg::OP_TIMER] = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            duart_pkg::ACT_ARRIVE:
            begin
                if (rx_en_reg[ech] && !rx_rdy_reg[ech] && !hwait_reg[ech])
                begin
                    hold_next[ech]    = item.line_byte;
                    rx_rdy_next[ech]  = 1'b1;
                    hwait_next[ech]   = 1'b1;
                    irq_next[erx_idx] = 1'b1;
                    result.rx_taken   = 1'b1;
                end
            end
            duart_pkg::ACT_DONE:
            begin
                tx_rdy_next[ech] = 1'b1;
                tx_emp_next[ech] = 1'b1;
                if (tx_en_reg[ech])
                begin
                    irq_next[etx_idx] = 1'b1;
                end
            end
            duart_pkg::ACT_RELEASE:
            begin
                hwait_next[ech] = 1'b0;
            end
            default:
            begin
            end
        endcase

        result.irq_modem_rx = irq_next[duart_pkg::IRQ_MRX];
        result.irq_modem_tx = irq_next[duart_pkg::IRQ_MTX];
        result.irq_diag_rx  = irq_next[duart_pkg::IRQ_DRX];
        result.irq_diag_tx  = irq_next[duart_pkg::IRQ_DTX];
        result.irq_timer    = irq_next[duart_pkg::IRQ_TMR];
        result.out_port     = port_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                mode_reg[i] <= '0;
            end
            hold_reg[0] <= '0;
            hold_reg[1] <= '0;
            mptr_reg    <= '0;
            rx_rdy_reg  <= '0;
            tx_rdy_reg  <= '0;
            tx_emp_reg  <= '0;
            hwait_reg   <= '0;
            rx_en_reg   <= '0;
            tx_en_reg   <= '0;
            port_reg    <= '0;
            cnt_reg     <= '0;
            pre_reg     <= '0;
            phase_reg   <= PH_STOP;
            tmode_reg   <= 1'b0;
            isr_reg     <= 1'b0;
            irq_reg     <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            hold_reg    <= hold_next;
            mptr_reg    <= mptr_next;
            rx_rdy_reg  <= rx_rdy_next;
            tx_rdy_reg  <= tx_rdy_next;
            tx_emp_reg  <= tx_emp_next;
            hwait_reg   <= hwait_next;
            rx_en_reg   <= rx_en_next;
            tx_en_reg   <= tx_en_next;
            port_reg    <= port_next;
            cnt_reg     <= cnt_next;
            pre_reg     <= pre_next;
            phase_reg   <= phase_next;
            tmode_reg   <= tmode_next;
            isr_reg     <= isr_next;
            irq_reg     <= irq_next;
        end
    end

endmodule

// ----- hdl/dual_uart_timer_register_block.sv -----
`timescale 1ns / 1ps

// two-channel uart register block with a 16-bit down-counting timer. each
// input word is one bus read, bus write or line event (timer tick, byte
// arrival, transmit done, receive-hold release) and yields exactly one result
// word carrying the read byte, all five interrupt levels, the output port,
// any transmit word started and whether an arriving byte was taken. the
// block takes one word per clock while the result side is not stalled: a
// word is captured in the input register, applied to the register file when
// it advances and lands in the result register. the input side keeps
// accepting while a result waits, and stalls only when the input register is
// full and the result register is held by out_ready low. channel 0 is the
// modem channel, channel 1 the diag channel; all register-file state clears
// on rst_n.

module dual_uart_timer_register_block (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  duart_pkg::in_t   in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output duart_pkg::out_t  out_data
);

    // input register
    logic            in_valid_reg;
    duart_pkg::in_t  in_data_reg;

    // result register
    logic            out_valid_reg;
    duart_pkg::out_t out_data_reg;

    duart_pkg::out_t result;
    logic            advance;

    // a word moves on when the result register is empty or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // register file and all per-word update logic
    duart_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_data_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/duart_chk.sv -----
`timescale 1ns / 1ps

module duart_chk (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  duart_pkg::in_t   in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  duart_pkg::out_t  out_data
);

    // an offered input word stays put until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input word changed while waiting");

    // a held result word does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // with nothing waiting at the output the input side must be open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // transmit fields are zero unless a transmission starts
    a_tx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.tx_start |->
            !out_data.tx_channel && out_data.tx_word == 9'd0)
        else $error("transmit fields set without a start");

    // modem channel never carries a mode bit, and a write reads nothing
    a_tx_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tx_start |->
            (out_data.tx_channel || !out_data.tx_word[8]) &&
            out_data.read_data == 8'd0 && !out_data.rx_taken)
        else $error("bad transmit result word");

endmodule

bind dual_uart_timer_register_block duart_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ----- sim/duart_result_checker.sv -----
`timescale 1ns / 1ps

module duart_result_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  duart_pkg::in_t   in_data,
    input  logic             out_valid,
    input  logic             out_ready,
    input  duart_pkg::out_t  out_data,
    output int unsigned      fail_count,
    output int unsigned      pending
);

    localparam logic [1:0] PH_STOPPED  = 2'd0;
    localparam logic [1:0] PH_ARMED    = 2'd1;
    localparam logic [1:0] PH_COUNTING = 2'd2;

    // shadow copy of the register file
    logic [7:0]  mode_reg [4];
    logic        mode_ptr [2];
    logic [7:0]  stat [2];
    logic [7:0]  hold [2];
    logic        hold_wait [2];
    logic        rx_en [2];
    logic        tx_en [2];
    logic [7:0]  port;
    logic [15:0] count;
    logic [15:0] preload;
    logic [1:0]  phase;
    logic        tmr_mode;
    logic        isr_tmr;
    logic [4:0]  irq;

    duart_pkg::out_t expected_results [$];
    int unsigned     mismatches = 0;

    assign fail_count = mismatches;

    task automatic predict_result(input duart_pkg::in_t w, output duart_pkg::out_t r);
        logic       c;
        logic       ch;
        logic [7:0] d;
        logic [2:0] cmd;
        r   = '0;
        c   = w.event_channel;
        ch  = w.reg_addr[3];
        d   = w.write_data;
        cmd = d[6:4];
        case (w.action)
            duart_pkg::ACT_READ:
                case (w.reg_addr)
                    duart_pkg::ADR_SR_A, duart_pkg::ADR_SR_B: r.read_data = stat[ch];
                    duart_pkg::ADR_HR_A, duart_pkg::ADR_HR_B:
                    begin
                        stat[ch][0] = 1'b0;
                        irq[ch ? duart_pkg::IRQ_DRX : duart_pkg::IRQ_MRX] = 1'b0;
                        r.read_data = hold[ch];
                    end
                    duart_pkg::ADR_ISR: r.read_data = {4'b0, isr_tmr, 3'b0};
                    duart_pkg::ADR_CTU: r.read_data = count[15:8];
                    duart_pkg::ADR_CTL: r.read_data = count[7:0];
                    duart_pkg::ADR_SETOP:
                    begin
                        count = preload;
                        phase = PH_ARMED;
                    end
                    duart_pkg::ADR_CLROP:
                    begin
                        phase = PH_STOPPED;
                        isr_tmr = 1'b0;
                        irq[duart_pkg::IRQ_TMR] = 1'b0;
                        if (tmr_mode)
                            port[duart_pkg::OP_TIMER] = 1'b0;
                    end
                    default: ;
                endcase
            duart_pkg::ACT_WRITE:
                case (w.reg_addr)
                    duart_pkg::ADR_MR_A, duart_pkg::ADR_MR_B:
                    begin
                        mode_reg[{ch, mode_ptr[ch]}] = d;
                        mode_ptr[ch] = ~mode_ptr[ch];
                    end
                    duart_pkg::ADR_CR_A, duart_pkg::ADR_CR_B:
                    begin
                        if (cmd == duart_pkg::CMD_RST_MRA || cmd == duart_pkg::CMD_RST_MRB)
                            mode_ptr[ch] = 1'b0;
                        else if (cmd == duart_pkg::CMD_RST_TX)
                        begin
                            tx_en[ch] = 1'b0;
                            stat[ch][2] = 1'b0;
                            irq[ch ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX] = 1'b0;
                        end
                        if (d[0])
                            rx_en[ch] = 1'b1;
                        if (d[1])
                            rx_en[ch] = 1'b0;
                        if (d[2] && !tx_en[ch])
                        begin
                            tx_en[ch] = 1'b1;
                            stat[ch][3:2] = 2'b11;
                            irq[ch ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX] = 1'b1;
                        end
                        if (d[3])
                        begin
                            tx_en[ch] = 1'b0;
                            stat[ch][3:2] = 2'b10;
                            irq[ch ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX] = 1'b0;
                        end
                    end
                    duart_pkg::ADR_HR_A, duart_pkg::ADR_HR_B:
                        // loopback when port bit 2 (diag only) or mode bit 7 is set
                        if ((ch && port[duart_pkg::OP_LOOP_B]) || mode_reg[{ch, 1'b1}][7])
                        begin
                            hold[ch] = d;
                            stat[ch][0] = 1'b1;
                        end
                        else
                        begin
                            stat[ch][3:2] = 2'b00;
                            irq[ch ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX] = 1'b0;
                            r.tx_start   = 1'b1;
                            r.tx_channel = ch;
                            r.tx_word    = {ch & mode_reg[2][2], d};
                        end
                    duart_pkg::ADR_CTU: preload[15:8] = d;
                    duart_pkg::ADR_CTL: preload[7:0] = d;
                    duart_pkg::ADR_OPCR: tmr_mode = (d[3:2] == 2'b01);
                    duart_pkg::ADR_SETOP:
                    begin
                        port = port | d;
                        if (port[duart_pkg::OP_MRX])
                            irq[duart_pkg::IRQ_MRX] = 1'b1;
                        if (port[duart_pkg::OP_DRX])
                            irq[duart_pkg::IRQ_DRX] = 1'b1;
                        if (port[duart_pkg::OP_DTX])
                            irq[duart_pkg::IRQ_DTX] = 1'b1;
                    end
                    duart_pkg::ADR_CLROP:
                    begin
                        port = port & ~d;
                        if (!port[duart_pkg::OP_MRX])
                            irq[duart_pkg::IRQ_MRX] = 1'b0;
                        if (!port[duart_pkg::OP_DRX])
                            irq[duart_pkg::IRQ_DRX] = 1'b0;
                        if (!port[duart_pkg::OP_DTX])
                            irq[duart_pkg::IRQ_DTX] = 1'b0;
                    end
                    default: ;
                endcase
            duart_pkg::ACT_TICK:
                if (phase == PH_ARMED)
                    phase = PH_COUNTING;
                else if (phase == PH_COUNTING)
                begin
                    count = count - 16'd1;
                    if (count == 16'd0)
                    begin
                        isr_tmr = 1'b1;
                        if (tmr_mode)
                        begin
                            irq[duart_pkg::IRQ_TMR] = 1'b1;
                            port[duart_pkg::OP_TIMER] = 1'b1;
                        end
                    end
                end
            duart_pkg::ACT_ARRIVE:
                if (rx_en[c] && !stat[c][0] && !hold_wait[c])
                begin
                    hold[c] = w.line_byte;
                    stat[c][0] = 1'b1;
                    hold_wait[c] = 1'b1;
                    irq[c ? duart_pkg::IRQ_DRX : duart_pkg::IRQ_MRX] = 1'b1;
                    r.rx_taken = 1'b1;
                end
            duart_pkg::ACT_DONE:
            begin
                stat[c][3:2] = 2'b11;
                if (tx_en[c])
                    irq[c ? duart_pkg::IRQ_DTX : duart_pkg::IRQ_MTX] = 1'b1;
            end
            duart_pkg::ACT_RELEASE: hold_wait[c] = 1'b0;
            default: ;
        endcase
        r.irq_modem_rx = irq[duart_pkg::IRQ_MRX];
        r.irq_modem_tx = irq[duart_pkg::IRQ_MTX];
        r.irq_diag_rx  = irq[duart_pkg::IRQ_DRX];
        r.irq_diag_tx  = irq[duart_pkg::IRQ_DTX];
        r.irq_timer    = irq[duart_pkg::IRQ_TMR];
        r.out_port     = port;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        duart_pkg::out_t want;
        duart_pkg::out_t pred;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
                mode_reg[i] = '0;
            for (int i = 0; i < 2; i++)
            begin
                mode_ptr[i]  = 1'b0;
                stat[i]      = '0;
                hold[i]      = '0;
                hold_wait[i] = 1'b0;
                rx_en[i]     = 1'b0;
                tx_en[i]     = 1'b0;
            end
            port     = '0;
            count    = '0;
            preload  = '0;
            phase    = PH_STOPPED;
            tmr_mode = 1'b0;
            isr_tmr  = 1'b0;
            irq      = '0;
            expected_results.delete();
            pending  = 0;
        end
        else
        begin
            // compare first: a result cannot belong to a word taken this edge
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("read_data",
                                32'(want.read_data), 32'(out_data.read_data));
                    check_field("irq_modem_rx",
                                32'(want.irq_modem_rx), 32'(out_data.irq_modem_rx));
                    check_field("irq_modem_tx",
                                32'(want.irq_modem_tx), 32'(out_data.irq_modem_tx));
                    check_field("irq_diag_rx",
                                32'(want.irq_diag_rx), 32'(out_data.irq_diag_rx));
                    check_field("irq_diag_tx",
                                32'(want.irq_diag_tx), 32'(out_data.irq_diag_tx));
                    check_field("irq_timer",
                                32'(want.irq_timer), 32'(out_data.irq_timer));
                    check_field("out_port",
                                32'(want.out_port), 32'(out_data.out_port));
                    check_field("tx_start",
                                32'(want.tx_start), 32'(out_data.tx_start));
                    check_field("tx_channel",
                                32'(want.tx_channel), 32'(out_data.tx_channel));
                    check_field("tx_word",
                                32'(want.tx_word), 32'(out_data.tx_word));
                    check_field("rx_taken",
                                32'(want.rx_taken), 32'(out_data.rx_taken));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_result(in_data, pred);
                expected_results.push_back(pred);
            end
            pending = expected_results.size();
        end
    end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;

    // action codes the block leaves alone
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int unsigned RANDOM_WORDS = 950;
    // receiver stall long enough to fill both internal slots
    localparam int unsigned HOLD_OFF     = 60;
    // idle cycles tolerated: well beyond the longest stall plus gaps
    localparam int unsigned IDLE_LIMIT   = 500;
    // two-stage pipe; extra settling wait after the last result
    localparam int unsigned DRAIN_CYCLES = 8;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    duart_pkg::in_t  in_data = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    duart_pkg::out_t out_data;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned words_sent = 0;
    // when set, neither side idles between words
    bit          steady = 1'b0;

    always #6 clk = ~clk;

    dual_uart_timer_register_block dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    duart_result_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    function automatic duart_pkg::in_t make_word(input logic [2:0] a, input logic [3:0] r,
                                                 input logic [7:0] d, input logic c,
                                                 input logic [7:0] b);
        duart_pkg::in_t w;
        w.action        = a;
        w.reg_addr      = r;
        w.write_data    = d;
        w.event_channel = c;
        w.line_byte     = b;
        return w;
    endfunction

    // one random word; unused fields carry noise too
    function automatic duart_pkg::in_t random_word();
        duart_pkg::in_t w;
        int unsigned    pick;
        w.reg_addr      = 4'($urandom_range(0, 15));
        w.write_data    = 8'($urandom_range(0, 255));
        w.event_channel = 1'($urandom_range(0, 1));
        w.line_byte     = 8'($urandom_range(0, 255));
        pick            = $urandom_range(0, 99);
        if (pick < 25)
            w.action = duart_pkg::ACT_READ;
        else if (pick < 58)
            w.action = duart_pkg::ACT_WRITE;
        else if (pick < 72)
            w.action = duart_pkg::ACT_TICK;
        else if (pick < 86)
            w.action = duart_pkg::ACT_ARRIVE;
        else if (pick < 92)
            w.action = duart_pkg::ACT_DONE;
        else if (pick < 98)
            w.action = duart_pkg::ACT_RELEASE;
        else
            w.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
        // command writes mostly enable, so traffic gets past the disabled state
        if (w.action == duart_pkg::ACT_WRITE &&
            (w.reg_addr == duart_pkg::ADR_CR_A || w.reg_addr == duart_pkg::ADR_CR_B)
            && $urandom_range(0, 3) != 0)
        begin
            w.write_data[1] = 1'b0;
            w.write_data[3] = 1'b0;
        end
        // a small preload lets the counter actually reach zero
        if (w.action == duart_pkg::ACT_WRITE && w.reg_addr == duart_pkg::ADR_CTU &&
            $urandom_range(0, 3) != 0)
            w.write_data = '0;
        return w;
    endfunction

    // offer one word after a random gap and hold it until taken
    task automatic send_word(input duart_pkg::in_t w);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
    endtask

    // receiver: random gap per word, with long hold-offs at two points
    initial
    begin : receiver
        int unsigned taken;
        int unsigned gap;
        taken = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (taken == 200 || taken == 650)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            else
            begin
                gap = steady ? 0 : $urandom_range(0, 5);
                if (gap != 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // watchdog: ends the run after too long without any word moving
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("dual_uart_timer_register_block verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned base;
        int unsigned k;
        logic        c;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset status, enables, mode pointer, both transmit paths
        send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_SR_A, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CR_A, 8'h05, 1'b0, 8'h00));
        // command value 1 resets the pointer, then rx and tx enable
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CR_B, 8'h15, 1'b1, 8'h00));
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_MR_B, 8'hFF, 1'b0, 8'h00));
        // diag transmit carries mode bit 2 as word bit 8
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_HR_B, 8'hA5, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_HR_A, 8'h00, 1'b0, 8'h00));
        // transmit done on the diag channel re-raises its tx interrupt
        send_word(make_word(duart_pkg::ACT_DONE, 4'hF, 8'hFF, 1'b1, 8'hFF));
        // arrival taken, then refused on a full holder, then on the hold
        send_word(make_word(duart_pkg::ACT_ARRIVE, 4'h0, 8'h00, 1'b0, 8'hFF));
        send_word(make_word(duart_pkg::ACT_ARRIVE, 4'h0, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_HR_A, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_ARRIVE, 4'h0, 8'h00, 1'b0, 8'h11));
        send_word(make_word(duart_pkg::ACT_RELEASE, 4'h0, 8'h00, 1'b0, 8'h00));
        // set every port bit: interrupts forced, diag loopback on
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_SETOP, 8'hFF, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_HR_B, 8'h5A, 1'b0, 8'h00));
        // clearing bit 5 lowers the diag receive interrupt
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CLROP, 8'h20, 1'b0, 8'h00));
        // timer: irq mode on, preload 1, start, arm tick, reach zero, wrap
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_OPCR, 8'h04, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CTL, 8'h01, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_SETOP, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_TICK, 4'h0, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_TICK, 4'h0, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_ISR, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_TICK, 4'h0, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_CTU, 8'h00, 1'b0, 8'h00));
        send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_CLROP, 8'h00, 1'b0, 8'h00));
        // transmitter reset command with both disables
        send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CR_A, 8'h3A, 1'b0, 8'h00));
        send_word(make_word(ACT_SPARE_HI, 4'hF, 8'hFF, 1'b1, 8'hFF));

        // random part, mixed with well-formed timer and receive sequences
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS)
        begin
            steady = (words_sent - base >= 400) && (words_sent - base < 520);
            case ($urandom_range(0, 11))
                0:
                begin
                    k = $urandom_range(1, 6);
                    send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_OPCR,
                                        $urandom_range(0, 1) ? 8'h04 : 8'h0C, 1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CTU, 8'h00,
                                        1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_WRITE, duart_pkg::ADR_CTL, 8'(k),
                                        1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_SETOP, 8'h00,
                                        1'b0, 8'h00));
                    repeat (k + 1)
                        send_word(make_word(duart_pkg::ACT_TICK, 4'h0, 8'h00, 1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_ISR, 8'h00,
                                        1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_CTL, 8'h00,
                                        1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_READ, duart_pkg::ADR_CLROP, 8'h00,
                                        1'b0, 8'h00));
                end
                1:
                begin
                    c = 1'($urandom_range(0, 1));
                    send_word(make_word(duart_pkg::ACT_WRITE,
                                        c ? duart_pkg::ADR_CR_B : duart_pkg::ADR_CR_A,
                                        8'h05, 1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_ARRIVE, 4'h0, 8'h00, c,
                                        8'($urandom_range(0, 255))));
                    send_word(make_word(duart_pkg::ACT_READ,
                                        c ? duart_pkg::ADR_SR_B : duart_pkg::ADR_SR_A,
                                        8'h00, 1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_READ,
                                        c ? duart_pkg::ADR_HR_B : duart_pkg::ADR_HR_A,
                                        8'h00, 1'b0, 8'h00));
                    send_word(make_word(duart_pkg::ACT_RELEASE, 4'h0, 8'h00, c, 8'h00));
                end
                default: send_word(random_word());
            endcase
        end
        in_valid <= 1'b0;

        // drain: let the last word reach the checker, then wait for every result
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("dual_uart_timer_register_block verification clean");
        else
            $display("dual_uart_timer_register_block verification failed");
        $finish;
    end

endmodule
